FILE: rtl/core/otdd_pkg.sv
// package with payload and state types of the offset table delta decoder
`default_nettype none

package otdd_pkg;

   localparam int unsigned DeltaWidth = 30;
   localparam int unsigned AddrWidth  = 32;

   // header kinds, taken from the top two bits of a header byte
   localparam logic [1:0] KIND_NONE  = 2'b00;
   localparam logic [1:0] KIND_SHORT = 2'b01;
   localparam logic [1:0] KIND_MID   = 2'b10;
   localparam logic [1:0] KIND_LONG  = 2'b11;

   // continuation bytes expected after a header
   localparam logic [1:0] PENDING_MID  = 2'd1;
   localparam logic [1:0] PENDING_LONG = 2'd3;

   typedef struct packed {
      logic [7:0] table_byte;
      logic       last_in_table;
   } otdd_req_type;

   typedef struct packed {
      logic [AddrWidth-1:0] rel_offset;
      logic [AddrWidth-1:0] abs_address;
      logic                 no_advance;
   } otdd_rsp_type;

   typedef struct packed {
      logic [AddrWidth-1:0]  running_offset;
      logic [1:0]            bytes_pending;
      logic [DeltaWidth-1:0] partial_delta;
   } otdd_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/otdd_decode.sv
// one-byte decode step: next decoder state and the result it completes
`default_nettype none

module otdd_decode (
   input  otdd_pkg::otdd_state_type       state,
   input  otdd_pkg::otdd_req_type         req,
   input  logic [otdd_pkg::AddrWidth-1:0] base_address,
   output otdd_pkg::otdd_state_type       state_next,
   output logic                           emit,
   output otdd_pkg::otdd_rsp_type         rsp
);

   logic [1:0]                       kind;
   logic [5:0]                       low;
   logic [otdd_pkg::DeltaWidth-1:0]  shifted_delta;
   logic [otdd_pkg::DeltaWidth-1:0]  delta;
   logic                             advance;
   logic                             flag;
   logic [otdd_pkg::AddrWidth-1:0]   offset_sum;

   assign kind          = req.table_byte[7:6];
   assign low           = req.table_byte[5:0];
   assign shifted_delta = {state.partial_delta[otdd_pkg::DeltaWidth-9:0], req.table_byte};

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      advance    = 1'b0;
      flag       = 1'b0;
      delta      = '0;
      if (state.bytes_pending == 2'd0) begin
         unique case (kind)
            otdd_pkg::KIND_LONG: begin
               state_next.partial_delta = {{(otdd_pkg::DeltaWidth-6){1'b0}}, low};
               state_next.bytes_pending = otdd_pkg::PENDING_LONG;
            end
            otdd_pkg::KIND_MID: begin
               state_next.partial_delta = {{(otdd_pkg::DeltaWidth-6){1'b0}}, low};
               state_next.bytes_pending = otdd_pkg::PENDING_MID;
            end
            otdd_pkg::KIND_SHORT: begin
               delta   = {{(otdd_pkg::DeltaWidth-6){1'b0}}, low};
               advance = 1'b1;
               emit    = 1'b1;
            end
            default: begin
               flag = 1'b1;
               emit = 1'b1;
            end
         endcase
      end else begin
         state_next.partial_delta = shifted_delta;
         state_next.bytes_pending = state.bytes_pending - 2'd1;
         if (state.bytes_pending == 2'd1) begin
            delta   = shifted_delta;
            advance = 1'b1;
            emit    = 1'b1;
         end
      end
      // word delta scaled to bytes
      offset_sum = state.running_offset + {delta, 2'b00};
      if (advance) begin
         state_next.running_offset = offset_sum;
      end
      // end of table: start the next table from a clean state
      if (req.last_in_table) begin
         state_next = '0;
      end
   end

   always_comb begin
      rsp.rel_offset  = advance ? offset_sum : state.running_offset;
      rsp.abs_address = base_address + rsp.rel_offset;
      rsp.no_advance  = flag;
   end

endmodule

`default_nettype wire

FILE: rtl/core/offset_table_delta_decoder_unit.sv
// top level of the offset table delta decoder
//
// Usage: table bytes enter on the req_ channel, one transaction per byte,
// with last_in_table set on the final byte of a table. Each completed
// group gives one transaction on the rsp_ channel carrying the running
// offset, base plus offset, and the no-advance flag for 00 headers.
// Header bytes of multi-byte groups and continuation bytes other than the
// last give no result; a group cut short by the end of the table is
// dropped. The base address is written on the csr_ channel (always
// ready); the user must do so only while the block is idle, which the
// block itself does not enforce. A byte in the input register is
// decoded combinationally and its result registered in the output
// register behind rsp_valid. Throughput: one byte per cycle, set by the
// single decode step between the two registers, while req_stall is low.
// Reset clears the decoder state, the base address and both valid flags.
// When rsp_stall is high the held result stays put; one more byte that
// completes a group waits in the input register and req_stall rises;
// bytes that complete nothing keep flowing.
`default_nettype none

module offset_table_delta_decoder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  otdd_pkg::otdd_req_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output otdd_pkg::otdd_rsp_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [otdd_pkg::AddrWidth-1:0] csr_data
);

   logic                           in_valid_ff;
   otdd_pkg::otdd_req_type         in_data_ff;
   otdd_pkg::otdd_state_type       state_ff;
   otdd_pkg::otdd_state_type       state_in;
   logic [otdd_pkg::AddrWidth-1:0] base_ff;
   logic                           out_valid_ff;
   otdd_pkg::otdd_rsp_type         out_data_ff;
   otdd_pkg::otdd_rsp_type         out_data_in;
   logic                           emit;
   logic                           advance;
   logic                           commit;

   otdd_decode u_decode (
      .state        (state_ff),
      .req          (in_data_ff),
      .base_address (base_ff),
      .state_next   (state_in),
      .emit         (emit),
      .rsp          (out_data_in)
   );

   // the input register moves on unless its result has nowhere to go
   assign advance   = !(emit && out_valid_ff && rsp_stall);
   assign commit    = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (commit && emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && emit) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a held result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

   // a last byte leaves the decoder clean
   a_table_end: assert property (@(posedge clock) disable iff (reset)
      (commit && in_data_ff.last_in_table) |=> (state_ff == '0))
      else $error("state not cleared at table end");

   // gathered delta never exceeds what the pending count allows
   a_delta_width_2: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_pending == 2'd2) |-> (state_ff.partial_delta[29:14] == '0))
      else $error("partial delta too wide with two bytes pending");

   a_delta_width_1: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_pending == 2'd1) |-> (state_ff.partial_delta[29:22] == '0))
      else $error("partial delta too wide with one byte pending");

   // the input stage only stalls behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && emit))
      else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
